// ----- rtl/core/gtg_pkg.sv -----
`default_nettype none
package gtg_pkg;

  localparam int VEC_W      = 40;
  localparam int ANG_W      = 28;
  localparam int COS_W      = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_CUTOFF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_SPEED_FLOOR = 3'd5;

  localparam logic signed [ANG_W-1:0] PI_Q24       = 28'sd52707179;
  localparam logic signed [21:0]      PI_Q16       = 22'sd205887;
  localparam logic signed [21:0]      TWO_PI_Q16   = 22'sd411775;
  localparam logic [21:0]             HALF_PI_Q16  = 22'd102944;
  localparam logic [23:0]             INV_GAIN_Q24 = 24'd10188012;
  localparam logic signed [COS_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic [16:0]             QUARTER_Q16  = 17'd16384;
  localparam logic [16:0]             ONE_Q16      = 17'd65536;
  localparam logic [33:0]             NEAR_DIST    = 34'd16384;
  localparam logic [16:0]             NEAR_FLOOR   = 17'd983;

  typedef struct packed {
    logic signed [18:0] yaw;
    logic               fin;
    logic               zero;
  } vec_side_t;

  typedef struct packed {
    logic [36:0]        v1;
    logic signed [17:0] w;
    logic               blocked;
    logic               big;
    logic               near;
  } rot_side_t;

  function automatic logic [23:0] atan_q24(input int i);
    logic [23:0] r;
    case (i)
      0: r = 24'd13176795;
      1: r = 24'd7778716;
      2: r = 24'd4110060;
      3: r = 24'd2086331;
      4: r = 24'd1047214;
      5: r = 24'd524117;
      6: r = 24'd262123;
      7: r = 24'd131069;
      8: r = 24'd65536;
      9: r = 24'd32768;
      10: r = 24'd16384;
      11: r = 24'd8192;
      12: r = 24'd4096;
      13: r = 24'd2048;
      14: r = 24'd1024;
      15: r = 24'd512;
      16: r = 24'd256;
      17: r = 24'd128;
      18: r = 24'd64;
      19: r = 24'd32;
      20: r = 24'd16;
      21: r = 24'd8;
      22: r = 24'd4;
      23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/go_to_goal_drive_law.sv -----
// path: input reg, vector cells, gain regs, rotation cells, speed and output regs
// throughput: one transaction per cycle unless stalled, set by the two cordic rows
// a stall on the output holds the whole pipeline in place
// reset: synchronous, clears valid bits and loads register defaults
`default_nettype none
module go_to_goal_drive_law #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [31:0]                robot_x,
  input  wire logic signed [31:0]                robot_y,
  input  wire logic signed [18:0]                robot_heading,
  input  wire logic signed [31:0]                goal_x,
  input  wire logic signed [31:0]                goal_y,
  input  wire logic                              final_goal,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [16:0]                            forward_speed,
  output logic signed [17:0]                     turn_rate,
  output logic                                   heading_blocked,
  input  wire logic                              cfg_we,
  input  wire logic [gtg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gtg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int N  = CORDIC_STAGES;
  localparam int VW = gtg_pkg::VEC_W;
  localparam int AW = gtg_pkg::ANG_W;
  localparam int CW = gtg_pkg::COS_W;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [17:0] turn_gain, speed_gain, heading_cutoff;
  logic [16:0] turn_rate_limit, speed_limit, curve_speed_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_gain         <= 18'd72090;
      turn_rate_limit   <= 17'd29491;
      speed_gain        <= 18'd45875;
      speed_limit       <= 17'd9175;
      heading_cutoff    <= 18'd114688;
      curve_speed_floor <= 17'd1966;
    end else if (cfg_we) begin
      case (cfg_index)
        gtg_pkg::CFG_TURN_GAIN:         turn_gain         <= cfg_data;
        gtg_pkg::CFG_TURN_RATE_LIMIT:   turn_rate_limit   <= cfg_data[16:0];
        gtg_pkg::CFG_SPEED_GAIN:        speed_gain        <= cfg_data;
        gtg_pkg::CFG_SPEED_LIMIT:       speed_limit       <= cfg_data[16:0];
        gtg_pkg::CFG_HEADING_CUTOFF:    heading_cutoff    <= cfg_data;
        gtg_pkg::CFG_CURVE_SPEED_FLOOR: curve_speed_floor <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // pre-rotation into the right half plane
  logic signed [32:0] dx, dy;
  logic signed [33:0] px, py;
  logic signed [VW-1:0] x0, y0;
  logic signed [AW-1:0] z0;
  gtg_pkg::vec_side_t s0;

  always_comb begin
    dx = {goal_x[31], goal_x} - {robot_x[31], robot_x};
    dy = {goal_y[31], goal_y} - {robot_y[31], robot_y};
    if (dx[32]) begin
      px = -{dx[32], dx};
      py = -{dy[32], dy};
      z0 = dy[32] ? -gtg_pkg::PI_Q24 : gtg_pkg::PI_Q24;
    end else begin
      px = {dx[32], dx};
      py = {dy[32], dy};
      z0 = '0;
    end
    x0 = {{(VW-38){px[33]}}, px, 4'b0000};
    y0 = {{(VW-38){py[33]}}, py, 4'b0000};
    s0.yaw  = robot_heading;
    s0.fin  = final_goal;
    s0.zero = (dx == 33'sd0) && (dy == 33'sd0);
  end

  logic                 vv [0:N];
  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];
  logic signed [AW-1:0] vz [0:N];
  gtg_pkg::vec_side_t   vs [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= in_valid;
    end
    if (en) begin
      vx[0] <= x0;
      vy[0] <= y0;
      vz[0] <= z0;
      vs[0] <= s0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    gtg_vec_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(vv[i]), .xin(vx[i]), .yin(vy[i]), .zin(vz[i]), .sin(vs[i]),
      .vout(vv[i+1]), .xout(vx[i+1]), .yout(vy[i+1]), .zout(vz[i+1]), .sout(vs[i+1])
    );
  end

  logic [6:1] pv;

  // magnitude scaling in two partial products, bearing rounding
  logic [43:0] pl, ph;
  logic signed [19:0] br;
  logic signed [18:0] yaw1;
  logic fin1;
  logic signed [AW-1:0] zr;

  assign zr = vz[N] + $signed(AW'(128));

  always_ff @(posedge clk) begin
    if (en) begin
      pl   <= vx[N][19:0] * gtg_pkg::INV_GAIN_Q24;
      ph   <= vx[N][39:20] * gtg_pkg::INV_GAIN_Q24;
      br   <= vs[N].zero ? 20'sd0 : zr[27:8];
      yaw1 <= vs[N].yaw;
      fin1 <= vs[N].fin;
    end
  end

  // distance and wrapped heading error
  logic [63:0] dsum;
  logic signed [21:0] e0, e1, e2;
  logic [33:0] range_q;
  logic signed [21:0] err;
  logic fin2;

  always_comb begin
    dsum = {ph, 20'b0} + {20'b0, pl} + 64'd134217728;
    e0 = {{2{br[19]}}, br} - {{3{yaw1[18]}}, yaw1};
    e1 = (e0 > gtg_pkg::PI_Q16) ? e0 - gtg_pkg::TWO_PI_Q16 : e0;
    e2 = (e1 < -gtg_pkg::PI_Q16) ? e1 + gtg_pkg::TWO_PI_Q16 : e1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_q <= dsum[61:28];
      err     <= e2;
      fin2    <= fin1;
    end
  end

  // gain products and heading tests
  logic [21:0] aerr;
  logic signed [40:0] tg;
  logic [51:0] sg;
  logic [21:0] a3;
  logic blk3, big3, near3;

  assign aerr = err[21] ? 22'(-err) : 22'(err);

  always_ff @(posedge clk) begin
    if (en) begin
      tg    <= $signed({1'b0, turn_gain}) * err;
      sg    <= speed_gain * range_q;
      a3    <= aerr;
      blk3  <= aerr > {4'b0, heading_cutoff};
      big3  <= aerr > gtg_pkg::HALF_PI_Q16;
      near3 <= fin2 && (range_q < gtg_pkg::NEAR_DIST);
    end
  end

  logic signed [40:0] tgr;
  logic signed [24:0] w0, lim25;
  logic [51:0] sgr;
  gtg_pkg::rot_side_t rs0;

  always_comb begin
    tgr   = tg + 41'sd32768;
    w0    = tgr[40:16];
    lim25 = $signed({8'b0, turn_rate_limit});
    sgr   = sg + 52'd32768;
    rs0.v1      = {1'b0, sgr[51:16]};
    rs0.blocked = blk3;
    rs0.big     = big3;
    rs0.near    = near3;
    if (w0 < -lim25) begin
      rs0.w = 18'(-lim25);
    end else if (w0 > lim25) begin
      rs0.w = lim25[17:0];
    end else begin
      rs0.w = w0[17:0];
    end
  end

  logic                 cv [0:N];
  logic signed [CW-1:0] cx [0:N];
  logic signed [CW-1:0] cy [0:N];
  logic signed [AW-1:0] cz [0:N];
  gtg_pkg::rot_side_t   cs [0:N];

  assign cv[0] = pv[3];
  assign cx[0] = gtg_pkg::INV_GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = $signed({1'b0, a3[18:0], 8'b0});
  assign cs[0] = rs0;

  for (genvar i = 0; i < N; i++) begin : g_rot
    gtg_rot_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(cv[i]), .xin(cx[i]), .yin(cy[i]), .zin(cz[i]), .sin(cs[i]),
      .vout(cv[i+1]), .xout(cx[i+1]), .yout(cy[i+1]), .zout(cz[i+1]), .sout(cs[i+1])
    );
  end

  // speed scale from the cosine
  logic signed [CW-1:0] cr;
  logic signed [18:0] c19;
  logic [16:0] cc;
  logic [16:0] scale;
  gtg_pkg::rot_side_t s4, s5;

  always_comb begin
    cr  = cx[N] + 33'sd8192;
    c19 = cr[32:14];
    if (c19 < 19'sd0) begin
      cc = '0;
    end else if (c19 > $signed({2'b0, gtg_pkg::ONE_Q16})) begin
      cc = gtg_pkg::ONE_Q16;
    end else begin
      cc = c19[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scale <= (cs[N].big || cc < gtg_pkg::QUARTER_Q16) ? gtg_pkg::QUARTER_Q16 : cc;
      s4    <= cs[N];
    end
  end

  logic [53:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= s4.v1 * scale;
      s5   <= s4;
    end
  end

  logic [53:0] pr;
  logic [37:0] v2;
  logic [16:0] floor_v, speed;

  always_comb begin
    pr      = prod + 54'd32768;
    v2      = pr[53:16];
    floor_v = s5.near ? gtg_pkg::NEAR_FLOOR : curve_speed_floor;
    if (s5.blocked) begin
      speed = '0;
    end else if (v2 < {21'b0, floor_v}) begin
      speed = floor_v;
    end else if (v2 > {21'b0, speed_limit}) begin
      speed = speed_limit;
    end else begin
      speed = v2[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv[1] <= vv[N];
      pv[2] <= pv[1];
      pv[3] <= pv[2];
      pv[4] <= cv[N];
      pv[5] <= pv[4];
      pv[6] <= pv[5];
    end
    if (en) begin
      forward_speed   <= speed;
      turn_rate       <= s5.w;
      heading_blocked <= s5.blocked;
    end
  end

  assign out_valid = pv[6];

  a_blocked_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && heading_blocked |-> forward_speed == 17'd0)
    else $error("blocked heading with nonzero speed");

  a_turn_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed({turn_rate[17], turn_rate}) <= $signed({2'b0, turn_rate_limit}))
      && ($signed({turn_rate[17], turn_rate}) >= -$signed({2'b0, turn_rate_limit})))
    else $error("turn rate beyond limit");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !heading_blocked |-> forward_speed <= speed_limit
      || forward_speed == gtg_pkg::NEAR_FLOOR || forward_speed == curve_speed_floor)
    else $error("forward speed outside clamp");

endmodule
`default_nettype wire

// ----- rtl/core/gtg_vec_cell.sv -----
`default_nettype none
module gtg_vec_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire logic                                 vin,
  input  wire logic signed [gtg_pkg::VEC_W-1:0]     xin,
  input  wire logic signed [gtg_pkg::VEC_W-1:0]     yin,
  input  wire logic signed [gtg_pkg::ANG_W-1:0]     zin,
  input  wire gtg_pkg::vec_side_t                   sin,
  output logic                                      vout,
  output logic signed [gtg_pkg::VEC_W-1:0]          xout,
  output logic signed [gtg_pkg::VEC_W-1:0]          yout,
  output logic signed [gtg_pkg::ANG_W-1:0]          zout,
  output gtg_pkg::vec_side_t                        sout
);

  localparam logic signed [gtg_pkg::ANG_W-1:0] ANG =
    $signed({4'b0000, gtg_pkg::atan_q24(STAGE)});

  logic signed [gtg_pkg::VEC_W-1:0] xs, ys, x_next, y_next;
  logic signed [gtg_pkg::ANG_W-1:0] z_next;

  always_comb begin
    xs = xin >>> STAGE;
    ys = yin >>> STAGE;
    if (!yin[gtg_pkg::VEC_W-1]) begin
      x_next = xin + ys;
      y_next = yin - xs;
      z_next = zin + ANG;
    end else begin
      x_next = xin - ys;
      y_next = yin + xs;
      z_next = zin - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      xout <= x_next;
      yout <= y_next;
      zout <= z_next;
      sout <= sin;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/gtg_rot_cell.sv -----
`default_nettype none
module gtg_rot_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire logic                                 vin,
  input  wire logic signed [gtg_pkg::COS_W-1:0]     xin,
  input  wire logic signed [gtg_pkg::COS_W-1:0]     yin,
  input  wire logic signed [gtg_pkg::ANG_W-1:0]     zin,
  input  wire gtg_pkg::rot_side_t                   sin,
  output logic                                      vout,
  output logic signed [gtg_pkg::COS_W-1:0]          xout,
  output logic signed [gtg_pkg::COS_W-1:0]          yout,
  output logic signed [gtg_pkg::ANG_W-1:0]          zout,
  output gtg_pkg::rot_side_t                        sout
);

  localparam logic signed [gtg_pkg::ANG_W-1:0] ANG =
    $signed({4'b0000, gtg_pkg::atan_q24(STAGE)});

  logic signed [gtg_pkg::COS_W-1:0] xs, ys, x_next, y_next;
  logic signed [gtg_pkg::ANG_W-1:0] z_next;

  always_comb begin
    xs = xin >>> STAGE;
    ys = yin >>> STAGE;
    if (!zin[gtg_pkg::ANG_W-1]) begin
      x_next = xin - ys;
      y_next = yin + xs;
      z_next = zin - ANG;
    end else begin
      x_next = xin + ys;
      y_next = yin - xs;
      z_next = zin + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      xout <= x_next;
      yout <= y_next;
      zout <= z_next;
      sout <= sin;
    end
  end

endmodule
`default_nettype wire
